[design/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants for the rotation matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ONE_Q14      = 16384;
    localparam int FRAC_W       = 14;
    localparam int ELEM_W       = 16;
    localparam int DIFF_W       = 17;
    localparam int RAD_W        = 17;
    localparam int ROOT_W       = 16;
    localparam int RCP_W        = 30;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int RCP_STAGES   = RCP_W;

    typedef logic [1:0] comp_t;

    localparam comp_t COMP_X = 2'd0;
    localparam comp_t COMP_Y = 2'd1;
    localparam comp_t COMP_Z = 2'd2;
    localparam comp_t COMP_W = 2'd3;

    // m00 in the lowest bits
    typedef struct packed {
        logic signed [ELEM_W-1:0] m22;
        logic signed [ELEM_W-1:0] m21;
        logic signed [ELEM_W-1:0] m20;
        logic signed [ELEM_W-1:0] m12;
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m10;
        logic signed [ELEM_W-1:0] m02;
        logic signed [ELEM_W-1:0] m01;
        logic signed [ELEM_W-1:0] m00;
    } mat_t;

    // scaled terms and where each one lands
    typedef struct packed {
        comp_t                    hsel;
        comp_t                    p0;
        comp_t                    p1;
        comp_t                    p2;
        logic signed [DIFF_W-1:0] d0;
        logic signed [DIFF_W-1:0] d1;
        logic signed [DIFF_W-1:0] d2;
    } side_t;

    // qx in the lowest bits
    typedef struct packed {
        logic signed [ELEM_W-1:0] qw;
        logic signed [ELEM_W-1:0] qz;
        logic signed [ELEM_W-1:0] qy;
        logic signed [ELEM_W-1:0] qx;
    } quat_t;

endpackage

[design/rmq_front.sv]
// ----------------------------------------------------------------------------
// rmq_front
// trace test, axis choice, radicand and off-diagonal terms, one stage
// ----------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  mat_t             in_mat,
    output logic             out_valid,
    output logic [RAD_W-1:0] out_rad,
    output side_t            out_side
);

    logic              valid_reg;
    logic [RAD_W-1:0]  rad_reg;
    side_t             side_reg;

    logic signed [17:0] tr;
    logic signed [18:0] rad_full;
    logic [RAD_W-1:0]   rad_next;
    side_t              side_next;
    logic [1:0]         axis;

    always_comb begin
        tr = in_mat.m00 + in_mat.m11 + in_mat.m22;
        axis = 2'd0;
        if (in_mat.m11 > in_mat.m00) begin
            axis = 2'd1;
        end
        if (in_mat.m22 > ((axis == 2'd1) ? in_mat.m11 : in_mat.m00)) begin
            axis = 2'd2;
        end
        if (tr > 18'sd0) begin
            rad_full       = 19'(tr) + 19'(ONE_Q14);
            side_next.hsel = COMP_W;
            side_next.d0   = in_mat.m12 - in_mat.m21;
            side_next.p0   = COMP_X;
            side_next.d1   = in_mat.m20 - in_mat.m02;
            side_next.p1   = COMP_Y;
            side_next.d2   = in_mat.m01 - in_mat.m10;
            side_next.p2   = COMP_Z;
        end else begin
            unique case (axis)
                2'd0: begin
                    rad_full = 19'(in_mat.m00) - 19'(in_mat.m11) - 19'(in_mat.m22)
                             + 19'(ONE_Q14);
                    side_next.hsel = COMP_X;
                    side_next.d0   = in_mat.m12 - in_mat.m21;
                    side_next.p0   = COMP_W;
                    side_next.d1   = in_mat.m01 + in_mat.m10;
                    side_next.p1   = COMP_Y;
                    side_next.d2   = in_mat.m02 + in_mat.m20;
                    side_next.p2   = COMP_Z;
                end
                2'd1: begin
                    rad_full = 19'(in_mat.m11) - 19'(in_mat.m22) - 19'(in_mat.m00)
                             + 19'(ONE_Q14);
                    side_next.hsel = COMP_Y;
                    side_next.d0   = in_mat.m20 - in_mat.m02;
                    side_next.p0   = COMP_W;
                    side_next.d1   = in_mat.m12 + in_mat.m21;
                    side_next.p1   = COMP_Z;
                    side_next.d2   = in_mat.m10 + in_mat.m01;
                    side_next.p2   = COMP_X;
                end
                default: begin
                    rad_full = 19'(in_mat.m22) - 19'(in_mat.m00) - 19'(in_mat.m11)
                             + 19'(ONE_Q14);
                    side_next.hsel = COMP_Z;
                    side_next.d0   = in_mat.m01 - in_mat.m10;
                    side_next.p0   = COMP_W;
                    side_next.d1   = in_mat.m20 + in_mat.m02;
                    side_next.p1   = COMP_X;
                    side_next.d2   = in_mat.m21 + in_mat.m12;
                    side_next.p2   = COMP_Y;
                end
            endcase
        end
        // negative radicand clamps to zero
        rad_next = (rad_full <= 19'sd0) ? '0 : rad_full[RAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_side  = side_reg;

endmodule

[design/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined integer square root of radicand * 2^14, one root bit per stage
// ----------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side
);

    localparam int VAL_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;

    logic              valid_reg [0:SQRT_STAGES-1];
    logic [REM_W-1:0]  rem_reg   [0:SQRT_STAGES-1];
    logic [ROOT_W-1:0] root_reg  [0:SQRT_STAGES-1];
    logic [VAL_W-1:0]  val_reg   [0:SQRT_STAGES-1];
    side_t             side_reg  [0:SQRT_STAGES-1];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic              cur_valid;
        logic [REM_W-1:0]  cur_rem;
        logic [ROOT_W-1:0] cur_root;
        logic [VAL_W-1:0]  cur_val;
        side_t             cur_side;
        logic [REM_W+1:0]  trial_rem;
        logic [REM_W:0]    trial_sub;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign cur_valid = in_valid;
            assign cur_rem   = '0;
            assign cur_root  = '0;
            assign cur_val   = {{(VAL_W-RAD_W-FRAC_W){1'b0}}, in_rad, {FRAC_W{1'b0}}};
            assign cur_side  = in_side;
        end else begin : g_next
            assign cur_valid = valid_reg[k-1];
            assign cur_rem   = rem_reg[k-1];
            assign cur_root  = root_reg[k-1];
            assign cur_val   = val_reg[k-1];
            assign cur_side  = side_reg[k-1];
        end

        always_comb begin
            trial_rem = {cur_rem, cur_val[VAL_W-1 -: 2]};
            trial_sub = {cur_root, 2'b01};
            if (trial_rem >= {1'b0, trial_sub}) begin
                rem_next  = REM_W'(trial_rem - {1'b0, trial_sub});
                root_next = {cur_root[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = trial_rem[REM_W-1:0];
                root_next = {cur_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= cur_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                val_reg[k]  <= {cur_val[VAL_W-3:0], 2'b00};
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

[design/rmq_recip.sv]
// ----------------------------------------------------------------------------
// rmq_recip
// pipelined restoring divide of 2^29 by the root, one quotient bit per stage
// ----------------------------------------------------------------------------
module rmq_recip
    import rmq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] in_root,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [RCP_W-1:0]  out_rcp,
    output side_t             out_side
);

    logic              valid_reg [0:RCP_STAGES-1];
    logic [ROOT_W-1:0] rem_reg   [0:RCP_STAGES-1];
    logic [ROOT_W-1:0] root_reg  [0:RCP_STAGES-1];
    logic [RCP_W-1:0]  quo_reg   [0:RCP_STAGES-1];
    side_t             side_reg  [0:RCP_STAGES-1];

    for (genvar k = 0; k < RCP_STAGES; k++) begin : g_stage
        logic              cur_valid;
        logic [ROOT_W-1:0] cur_rem;
        logic [ROOT_W-1:0] cur_root;
        logic [RCP_W-1:0]  cur_quo;
        side_t             cur_side;
        logic [ROOT_W:0]   trial;
        logic              qbit;
        logic [ROOT_W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign cur_valid = in_valid;
            assign cur_rem   = '0;
            assign cur_root  = in_root;
            assign cur_quo   = '0;
            assign cur_side  = in_side;
        end else begin : g_next
            assign cur_valid = valid_reg[k-1];
            assign cur_rem   = rem_reg[k-1];
            assign cur_root  = root_reg[k-1];
            assign cur_quo   = quo_reg[k-1];
            assign cur_side  = side_reg[k-1];
        end

        // dividend has its only set bit at the top
        always_comb begin
            trial = {cur_rem, (k == 0) ? 1'b1 : 1'b0};
            qbit  = (trial >= {1'b0, cur_root});
            rem_next = qbit ? ROOT_W'(trial - {1'b0, cur_root}) : trial[ROOT_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= cur_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= cur_root;
                quo_reg[k]  <= {cur_quo[RCP_W-2:0], qbit};
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_valid = valid_reg[RCP_STAGES-1];
    assign out_root  = root_reg[RCP_STAGES-1];
    assign out_rcp   = quo_reg[RCP_STAGES-1];
    assign out_side  = side_reg[RCP_STAGES-1];

endmodule

[design/rmq_back.sv]
// ----------------------------------------------------------------------------
// rmq_back
// scale terms by the reciprocal, floor, saturate and route to components
// ----------------------------------------------------------------------------
module rmq_back
    import rmq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] in_root,
    input  logic [RCP_W-1:0]  in_rcp,
    input  side_t             in_side,
    output logic              out_valid,
    output quat_t             out_quat
);

    localparam int PROD_W = DIFF_W + RCP_W + 1;
    localparam int SHR_W  = PROD_W - 16;

    logic                     mvalid_reg;
    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic [ROOT_W-1:0]        root_reg;
    side_t                    side_reg;
    logic                     valid_reg;
    quat_t                    quat_reg;

    logic signed [RCP_W:0]    rcp_s;
    logic signed [ELEM_W-1:0] t0;
    logic signed [ELEM_W-1:0] t1;
    logic signed [ELEM_W-1:0] t2;
    logic signed [ELEM_W-1:0] half;
    logic signed [ELEM_W-1:0] comp_next [0:3];
    quat_t                    quat_next;

    function automatic logic signed [ELEM_W-1:0] sat_term(logic signed [PROD_W-1:0] p);
        logic signed [SHR_W-1:0] sh;
        sh = SHR_W'(p >>> 16);
        if (sh > SHR_W'(32767)) begin
            return 16'sh7fff;
        end else if (sh < -SHR_W'(32768)) begin
            return -16'sh8000;
        end
        return sh[ELEM_W-1:0];
    endfunction

    assign rcp_s = $signed({1'b0, in_rcp});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else if (en) begin
            mvalid_reg <= in_valid;
            valid_reg  <= mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg   <= PROD_W'(in_side.d0) * PROD_W'(rcp_s);
            p1_reg   <= PROD_W'(in_side.d1) * PROD_W'(rcp_s);
            p2_reg   <= PROD_W'(in_side.d2) * PROD_W'(rcp_s);
            root_reg <= in_root;
            side_reg <= in_side;
        end
    end

    always_comb begin
        t0   = sat_term(p0_reg);
        t1   = sat_term(p1_reg);
        t2   = sat_term(p2_reg);
        half = $signed({1'b0, root_reg[ROOT_W-1:1]});
        for (int c = 0; c < 4; c++) begin
            if (root_reg == '0) begin
                comp_next[c] = '0;
            end else if (side_reg.hsel == comp_t'(c)) begin
                comp_next[c] = half;
            end else if (side_reg.p0 == comp_t'(c)) begin
                comp_next[c] = t0;
            end else if (side_reg.p1 == comp_t'(c)) begin
                comp_next[c] = t1;
            end else begin
                comp_next[c] = t2;
            end
        end
        quat_next.qx = comp_next[COMP_X];
        quat_next.qy = comp_next[COMP_Y];
        quat_next.qz = comp_next[COMP_Z];
        quat_next.qw = comp_next[COMP_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quat_reg <= quat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_quat  = quat_reg;

endmodule

[design/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix to quaternion by the trace method, signed Q2.14
// ----------------------------------------------------------------------------
// Takes one matrix per clock while the skid register is empty, and returns one
// quaternion per matrix, in order. It has one setup stage, 16 square-root
// stages (one root bit each), 30 reciprocal stages (one quotient bit each), a
// multiply stage and a saturate/route stage. A one-entry skid register at the
// output holds the pipeline's last result when the sink stalls; the pipeline
// freezes while that register is full, so s_tready follows the skid state only.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // qx, qy, qz, qw
);

    logic              en;
    logic              skid_valid_reg;
    quat_t             skid_reg;

    logic              f_valid;
    logic [RAD_W-1:0]  f_rad;
    side_t             f_side;
    logic              q_valid;
    logic [ROOT_W-1:0] q_root;
    side_t             q_side;
    logic              r_valid;
    logic [ROOT_W-1:0] r_root;
    logic [RCP_W-1:0]  r_rcp;
    side_t             r_side;
    logic              b_valid;
    quat_t             b_quat;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    rmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_mat    (mat_t'(s_tdata)),
        .out_valid (f_valid),
        .out_rad   (f_rad),
        .out_side  (f_side)
    );

    rmq_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_rad    (f_rad),
        .in_side   (f_side),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_side)
    );

    rmq_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_root   (q_root),
        .in_side   (q_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_rcp   (r_rcp),
        .out_side  (r_side)
    );

    rmq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_root   (r_root),
        .in_rcp    (r_rcp),
        .in_side   (r_side),
        .out_valid (b_valid),
        .out_quat  (b_quat)
    );

    // park the last stage result when the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (b_valid && !m_tready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg && b_valid && !m_tready) begin
            skid_reg <= b_quat;
        end
    end

    assign m_tvalid = skid_valid_reg || b_valid;
    assign m_tdata  = skid_valid_reg ? skid_reg : b_quat;

endmodule
